// ===== design/buddy_allocator_core_defines.svh =====
// Assertion macros for the buddy allocator core.
`ifndef BUDDY_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

// ===== design/ba_pkg.sv =====
// Shared types, constants and helper functions of the buddy allocator.
package ba_pkg;

    localparam int MIN_LOG2     = 5;
    localparam int LEVELS       = 16;
    localparam int HEADER_BYTES = 8;

    localparam int UNIT_W = LEVELS - 1;
    localparam int UNITS  = 1 << UNIT_W;
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int LVC_W  = 6;

    localparam int ACT_W = 2;
    localparam int REQ_W = 21;
    localparam int OFF_W = 20;
    localparam int USE_W = 21;
    localparam int STS_W = 2;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REALLOC = 2'd2;

    localparam logic [STS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STS_W-1:0] STATUS_NO_MEMORY = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [REQ_W-1:0] req_bytes;
        logic [OFF_W-1:0] user_offset;
    } in_word_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [OFF_W-1:0] result_offset;
        logic [USE_W-1:0] usable_bytes;
    } out_word_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_FREE_CHK,
        CMD_FREE_USED,
        CMD_MERGE_RD,
        CMD_MERGE_RM,
        CMD_SETTLE,
        CMD_AP_START,
        CMD_AP_LINK,
        CMD_AP_CLOSE,
        CMD_ALLOC_CHK,
        CMD_ALLOC_RM,
        CMD_SPLIT,
        CMD_ALLOC_FIN,
        CMD_REPORT
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic act_free;
        logic act_alloc;
        logic free_ok;
        logic unit_used;
        logic merge_go;
        logic bud_free;
        logic ap_nonempty;
        logic too_large;
        logic no_block;
        logic split_go;
    } dp_status_t;

    // Smallest p with (1 << p) >= r, taking zero as one.
    function automatic logic [LVC_W-1:0] ceil_log2(input logic [REQ_W-1:0] r);
        logic [REQ_W-1:0] v;
        logic [LVC_W-1:0] p;
        v = r - REQ_W'(1);
        p = '0;
        if (r > REQ_W'(1))
        begin
            for (int i = 0; i < REQ_W; i++)
            begin
                if (v[i])
                begin
                    p = LVC_W'(i + 1);
                end
            end
        end
        return p;
    endfunction

endpackage

// ===== design/ba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/ba_ctrl.sv =====
// Sequencing state machine of the buddy allocator.
module ba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ba_pkg::dp_status_t st,
    output ba_pkg::cmd_t       cmd,
    output logic               busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_FREE_CHK,
        S_FREE_USED,
        S_MERGE_RD,
        S_MERGE_RM,
        S_SETTLE,
        S_AP_START,
        S_AP_LINK,
        S_AP_CLOSE,
        S_ALLOC_CHK,
        S_ALLOC_RM,
        S_SPLIT,
        S_ALLOC_FIN,
        S_REPORT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   split_phase_reg;
    logic   split_phase_next;
    state_t post_free;
    state_t split_or_fin;
    state_t ap_return;

    always_comb
    begin
        post_free    = st.act_alloc ? S_ALLOC_CHK : S_REPORT;
        split_or_fin = st.split_go ? S_SPLIT : S_ALLOC_FIN;
        ap_return    = split_phase_reg ? split_or_fin : post_free;
    end

    always_comb
    begin
        state_next       = state_reg;
        split_phase_next = split_phase_reg;
        cmd              = ba_pkg::CMD_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd        = ba_pkg::CMD_CLEAR;
                state_next = st.clear_last ? S_IDLE : S_CLEAR;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = ba_pkg::CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.act_free)
                begin
                    state_next = S_FREE_CHK;
                end
                else
                begin
                    state_next = post_free;
                end
            end
            S_FREE_CHK:
            begin
                cmd        = ba_pkg::CMD_FREE_CHK;
                state_next = st.free_ok ? S_FREE_USED : post_free;
            end
            S_FREE_USED:
            begin
                cmd        = ba_pkg::CMD_FREE_USED;
                state_next = st.unit_used ? S_MERGE_RD : post_free;
            end
            S_MERGE_RD:
            begin
                cmd        = ba_pkg::CMD_MERGE_RD;
                state_next = st.merge_go ? S_MERGE_RM : S_SETTLE;
            end
            S_MERGE_RM:
            begin
                cmd        = ba_pkg::CMD_MERGE_RM;
                state_next = st.bud_free ? S_MERGE_RD : S_SETTLE;
            end
            S_SETTLE:
            begin
                cmd              = ba_pkg::CMD_SETTLE;
                split_phase_next = 1'b0;
                state_next       = S_AP_START;
            end
            S_AP_START:
            begin
                cmd        = ba_pkg::CMD_AP_START;
                state_next = st.ap_nonempty ? S_AP_LINK : ap_return;
            end
            S_AP_LINK:
            begin
                cmd        = ba_pkg::CMD_AP_LINK;
                state_next = S_AP_CLOSE;
            end
            S_AP_CLOSE:
            begin
                cmd        = ba_pkg::CMD_AP_CLOSE;
                state_next = ap_return;
            end
            S_ALLOC_CHK:
            begin
                cmd        = ba_pkg::CMD_ALLOC_CHK;
                state_next = (st.too_large || st.no_block) ? S_REPORT : S_ALLOC_RM;
            end
            S_ALLOC_RM:
            begin
                cmd        = ba_pkg::CMD_ALLOC_RM;
                state_next = split_or_fin;
            end
            S_SPLIT:
            begin
                cmd              = ba_pkg::CMD_SPLIT;
                split_phase_next = 1'b1;
                state_next       = S_AP_START;
            end
            S_ALLOC_FIN:
            begin
                cmd        = ba_pkg::CMD_ALLOC_FIN;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                cmd        = ba_pkg::CMD_REPORT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            split_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            split_phase_reg <= split_phase_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== design/ba_datapath.sv =====
// Datapath of the buddy allocator: unit memories, free lists and result word.
module ba_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ba_pkg::cmd_t       cmd,
    input  ba_pkg::in_word_t   item,
    output ba_pkg::dp_status_t st,
    output ba_pkg::out_word_t  result,
    output logic               done
);

    localparam int UW = ba_pkg::UNIT_W;
    localparam int LW = ba_pkg::LVL_W;
    localparam int CW = ba_pkg::LVC_W;
    localparam int BW = ba_pkg::OFF_W + 1;

    logic [ba_pkg::ACT_W-1:0] act_reg;
    logic [ba_pkg::REQ_W-1:0] req_reg;
    logic [ba_pkg::OFF_W-1:0] off_reg;
    logic [UW-1:0]            u_reg;
    logic [LW-1:0]            lvl_reg;
    logic [LW-1:0]            fl_reg;
    logic [UW-1:0]            bud_reg;
    logic [UW-1:0]            ap_u_reg;
    logic [LW-1:0]            ap_lvl_reg;
    logic [UW-1:0]            t_reg;
    logic [UW-1:0]            clr_reg;
    logic [UW-1:0]            head_reg [ba_pkg::LEVELS];
    logic [ba_pkg::LEVELS-1:0] nonempty_reg;
    ba_pkg::out_word_t        result_reg;
    logic                     done_reg;

    logic [UW-1:0] raddr;
    logic          lvl_we, used_we, next_we, prev_we;
    logic [UW-1:0] lvl_wa, used_wa, next_wa, prev_wa;
    logic [LW-1:0] lvl_wd;
    logic          used_wd;
    logic [UW-1:0] next_wd, prev_wd;
    logic [LW-1:0] level_rd;
    logic          used_rd;
    logic [UW-1:0] next_rd, prev_rd;

    logic [BW-1:0] off_ext;
    logic [BW-1:0] b_full;
    logic          free_ok;
    logic [UW-1:0] b_unit;
    logic [UW-1:0] bud_c;
    logic [UW-1:0] bud_s;
    logic [LW-1:0] fl_dec;
    logic [CW-1:0] p_c;
    logic [CW-1:0] lvl_c6;
    logic          too_large;
    logic          found;
    logic [LW-1:0] fl_c;
    logic [UW-1:0] ap_head;
    logic [LW-1:0] level_clamped;
    logic [CW-1:0] shift_amt;
    logic [ba_pkg::USE_W-1:0] size_c;
    logic [ba_pkg::USE_W-1:0] usable_c;
    logic [ba_pkg::OFF_W-1:0] offset_c;

    always_comb
    begin
        off_ext = BW'(off_reg);
        b_full  = off_ext - BW'(ba_pkg::HEADER_BYTES);
        free_ok = (off_ext >= BW'(ba_pkg::HEADER_BYTES))
                  && (b_full[ba_pkg::MIN_LOG2-1:0] == '0)
                  && ((b_full >> ba_pkg::MIN_LOG2) < BW'(ba_pkg::UNITS));
        b_unit  = b_full[ba_pkg::MIN_LOG2 +: UW];

        bud_c  = u_reg ^ (UW'(1) << lvl_reg);
        fl_dec = fl_reg - LW'(1);
        bud_s  = u_reg ^ (UW'(1) << fl_dec);

        p_c       = ba_pkg::ceil_log2(req_reg);
        lvl_c6    = (p_c > CW'(ba_pkg::MIN_LOG2)) ? p_c - CW'(ba_pkg::MIN_LOG2) : '0;
        too_large = (lvl_c6 >= CW'(ba_pkg::LEVELS));
        found     = 1'b0;
        fl_c      = '0;
        for (int i = ba_pkg::LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i] && (CW'(i) >= lvl_c6))
            begin
                found = 1'b1;
                fl_c  = LW'(i);
            end
        end

        ap_head       = head_reg[ap_lvl_reg];
        level_clamped = (level_rd > LW'(ba_pkg::LEVELS - 1)) ?
                        LW'(ba_pkg::LEVELS - 1) : level_rd;

        shift_amt = CW'(lvl_reg) + CW'(ba_pkg::MIN_LOG2);
        size_c    = ba_pkg::USE_W'(1) << shift_amt;
        usable_c  = (size_c > ba_pkg::USE_W'(ba_pkg::HEADER_BYTES)) ?
                    size_c - ba_pkg::USE_W'(ba_pkg::HEADER_BYTES) : '0;
        offset_c  = ba_pkg::OFF_W'({u_reg, {ba_pkg::MIN_LOG2{1'b0}}})
                    + ba_pkg::OFF_W'(ba_pkg::HEADER_BYTES);
    end

    always_comb
    begin
        st.clear_last  = (clr_reg == UW'(ba_pkg::UNITS - 1));
        st.act_free    = (act_reg == ba_pkg::ACT_FREE) || (act_reg == ba_pkg::ACT_REALLOC);
        st.act_alloc   = (act_reg == ba_pkg::ACT_ALLOC) || (act_reg == ba_pkg::ACT_REALLOC);
        st.free_ok     = free_ok;
        st.unit_used   = used_rd;
        st.merge_go    = (lvl_reg < LW'(ba_pkg::LEVELS - 1));
        st.bud_free    = !used_rd && (level_rd == lvl_reg);
        st.ap_nonempty = nonempty_reg[ap_lvl_reg];
        st.too_large   = too_large;
        st.no_block    = !found;
        st.split_go    = (fl_reg > lvl_reg);
    end

    always_comb
    begin
        raddr   = u_reg;
        lvl_we  = 1'b0;
        used_we = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        lvl_wa  = u_reg;
        used_wa = u_reg;
        next_wa = u_reg;
        prev_wa = u_reg;
        lvl_wd  = '0;
        used_wd = 1'b0;
        next_wd = '0;
        prev_wd = '0;
        case (cmd)
            ba_pkg::CMD_CLEAR:
            begin
                lvl_we  = 1'b1;
                used_we = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
                lvl_wa  = clr_reg;
                used_wa = clr_reg;
                next_wa = clr_reg;
                prev_wa = clr_reg;
                lvl_wd  = (clr_reg == '0) ? LW'(ba_pkg::LEVELS - 1) : '0;
            end
            ba_pkg::CMD_FREE_CHK:
            begin
                raddr = b_unit;
            end
            ba_pkg::CMD_FREE_USED:
            begin
                used_we = 1'b1;
            end
            ba_pkg::CMD_MERGE_RD:
            begin
                raddr = bud_c;
            end
            ba_pkg::CMD_MERGE_RM:
            begin
                if (st.bud_free && (next_rd != bud_reg))
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd;
                    next_wd = next_rd;
                    prev_we = 1'b1;
                    prev_wa = next_rd;
                    prev_wd = prev_rd;
                end
            end
            ba_pkg::CMD_SETTLE:
            begin
                lvl_we  = 1'b1;
                lvl_wd  = lvl_reg;
                used_we = 1'b1;
            end
            ba_pkg::CMD_AP_START:
            begin
                raddr = ap_head;
                if (!nonempty_reg[ap_lvl_reg])
                begin
                    next_we = 1'b1;
                    next_wa = ap_u_reg;
                    next_wd = ap_u_reg;
                    prev_we = 1'b1;
                    prev_wa = ap_u_reg;
                    prev_wd = ap_u_reg;
                end
            end
            ba_pkg::CMD_AP_LINK:
            begin
                prev_we = 1'b1;
                prev_wa = ap_u_reg;
                prev_wd = prev_rd;
                next_we = 1'b1;
                next_wa = ap_u_reg;
                next_wd = ap_head;
            end
            ba_pkg::CMD_AP_CLOSE:
            begin
                next_we = 1'b1;
                next_wa = t_reg;
                next_wd = ap_u_reg;
                prev_we = 1'b1;
                prev_wa = ap_head;
                prev_wd = ap_u_reg;
            end
            ba_pkg::CMD_ALLOC_CHK:
            begin
                raddr = head_reg[fl_c];
            end
            ba_pkg::CMD_ALLOC_RM:
            begin
                if (next_rd != u_reg)
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd;
                    next_wd = next_rd;
                    prev_we = 1'b1;
                    prev_wa = next_rd;
                    prev_wd = prev_rd;
                end
            end
            ba_pkg::CMD_SPLIT:
            begin
                lvl_we  = 1'b1;
                lvl_wa  = bud_s;
                lvl_wd  = fl_dec;
                used_we = 1'b1;
                used_wa = bud_s;
            end
            ba_pkg::CMD_ALLOC_FIN:
            begin
                lvl_we  = 1'b1;
                lvl_wd  = lvl_reg;
                used_we = 1'b1;
                used_wd = 1'b1;
            end
            default:
            begin
                raddr = u_reg;
            end
        endcase
    end

    ba_ram #(.WIDTH(LW), .DEPTH(ba_pkg::UNITS)) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_wa),
        .wdata (lvl_wd),
        .raddr (raddr),
        .rdata (level_rd)
    );

    ba_ram #(.WIDTH(1), .DEPTH(ba_pkg::UNITS)) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_wa),
        .wdata (used_wd),
        .raddr (raddr),
        .rdata (used_rd)
    );

    ba_ram #(.WIDTH(UW), .DEPTH(ba_pkg::UNITS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_wa),
        .wdata (next_wd),
        .raddr (raddr),
        .rdata (next_rd)
    );

    ba_ram #(.WIDTH(UW), .DEPTH(ba_pkg::UNITS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_wa),
        .wdata (prev_wd),
        .raddr (raddr),
        .rdata (prev_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            done_reg     <= 1'b0;
            nonempty_reg <= ba_pkg::LEVELS'(1) << (ba_pkg::LEVELS - 1);
            for (int i = 0; i < ba_pkg::LEVELS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= (cmd == ba_pkg::CMD_REPORT);
            case (cmd)
                ba_pkg::CMD_CLEAR:
                begin
                    clr_reg <= clr_reg + UW'(1);
                end
                ba_pkg::CMD_MERGE_RM:
                begin
                    if (st.bud_free)
                    begin
                        if (next_rd == bud_reg)
                        begin
                            nonempty_reg[lvl_reg] <= 1'b0;
                        end
                        else
                        begin
                            head_reg[lvl_reg] <= prev_rd;
                        end
                    end
                end
                ba_pkg::CMD_AP_START:
                begin
                    if (!nonempty_reg[ap_lvl_reg])
                    begin
                        head_reg[ap_lvl_reg]     <= ap_u_reg;
                        nonempty_reg[ap_lvl_reg] <= 1'b1;
                    end
                end
                ba_pkg::CMD_ALLOC_RM:
                begin
                    if (next_rd == u_reg)
                    begin
                        nonempty_reg[fl_reg] <= 1'b0;
                    end
                    else
                    begin
                        head_reg[fl_reg] <= prev_rd;
                    end
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            ba_pkg::CMD_LOAD:
            begin
                act_reg    <= item.action;
                req_reg    <= item.req_bytes;
                off_reg    <= item.user_offset;
                result_reg <= '0;
            end
            ba_pkg::CMD_FREE_CHK:
            begin
                u_reg <= b_unit;
            end
            ba_pkg::CMD_FREE_USED:
            begin
                lvl_reg <= level_clamped;
            end
            ba_pkg::CMD_MERGE_RD:
            begin
                bud_reg <= bud_c;
            end
            ba_pkg::CMD_MERGE_RM:
            begin
                if (st.bud_free)
                begin
                    u_reg   <= u_reg & ~(UW'(1) << lvl_reg);
                    lvl_reg <= lvl_reg + LW'(1);
                end
            end
            ba_pkg::CMD_SETTLE:
            begin
                ap_u_reg   <= u_reg;
                ap_lvl_reg <= lvl_reg;
            end
            ba_pkg::CMD_AP_LINK:
            begin
                t_reg <= prev_rd;
            end
            ba_pkg::CMD_ALLOC_CHK:
            begin
                lvl_reg <= lvl_c6[LW-1:0];
                fl_reg  <= fl_c;
                u_reg   <= head_reg[fl_c];
                if (too_large)
                begin
                    result_reg.status <= ba_pkg::STATUS_TOO_LARGE;
                end
                else if (!found)
                begin
                    result_reg.status <= ba_pkg::STATUS_NO_MEMORY;
                end
            end
            ba_pkg::CMD_SPLIT:
            begin
                fl_reg     <= fl_dec;
                ap_u_reg   <= bud_s;
                ap_lvl_reg <= fl_dec;
            end
            ba_pkg::CMD_ALLOC_FIN:
            begin
                result_reg.status        <= ba_pkg::STATUS_OK;
                result_reg.result_offset <= offset_c;
                result_reg.usable_bytes  <= usable_c;
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== design/buddy_allocator_core.sv =====
// Top level of the buddy allocator: controller, datapath and interface checks.
//
// A request word is taken when start is high and busy is low; its single result
// word appears on result for one cycle with done high, and must be taken then.
// After reset the block sweeps its unit tables with busy high. A request holds busy
// while it checks a free, walks the merge steps, ends the merge walk and settles the
// freed block, searches for an allocation and removes and finishes it when granted,
// and splits level by level, with a free-list append after each settle and split.
// The result appears in the same cycle that busy falls. Each unit table has a single
// read and write port, so these steps run one after another.
`include "buddy_allocator_core_defines.svh"

module buddy_allocator_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ba_pkg::in_word_t  item,
    output ba_pkg::out_word_t result,
    output logic              done
);

    ba_pkg::cmd_t       cmd;
    ba_pkg::dp_status_t st;

    ba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    ba_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .st     (st),
        .result (result),
        .done   (done)
    );

    `BA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `BA_ASSERT_IMP(a_done_idle, done, !busy)
    `BA_ASSERT_NXT(a_done_single, done, !done)
    `BA_ASSERT_IMP(a_err_zero, done && (result.status != ba_pkg::STATUS_OK),
                   (result.result_offset == '0) && (result.usable_bytes == '0))

endmodule
